// ===== rtl/running_median_assert.svh =====
// Assertion macros used by the checker module of this block.
`ifndef RUNNING_MEDIAN_ASSERT_SVH
`define RUNNING_MEDIAN_ASSERT_SVH

// Same-cycle implication, disabled while reset is active.
`define RM_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("running_median: implication check failed");

// Next-cycle implication, disabled while reset is active.
`define RM_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("running_median: next-cycle check failed");

`endif

// ===== rtl/rm_pkg.sv =====
`default_nettype none

package rm_pkg;

  localparam int unsigned SAMPLE_W     = 32;
  localparam int unsigned COUNT_W      = 7;
  localparam int unsigned CAPACITY_DEF = 64;

  // Operation broadcast to every cell of a chain.
  typedef enum logic [1:0] {
    OP_HOLD   = 2'd0,
    OP_INSERT = 2'd1,
    OP_POP    = 2'd2,
    OP_PUSH   = 2'd3
  } cell_op_e;

  // Broadcast to all cells: the operation and the value it carries.
  typedef struct packed {
    cell_op_e                    op;
    logic signed [SAMPLE_W-1:0]  data;
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/running_median.sv =====
// Running median of a signed 32-bit sample stream.
//
// Input channel: in_valid_i/in_ready_o carry sample_i and restart_i. A set
// restart_i empties the store before the sample is added. Output channel:
// out_valid_o/out_ready_i carry median_value_o, sample_count_o and
// overflow_o; every input transaction yields exactly one output transaction.
// Once CAPACITY samples are held, further samples are dropped, overflow_o is
// set and the median of the held samples is reported again.
//
// On acceptance the sample is inserted into a chain, the chains are then
// rebalanced and the median is loaded into the output register, through the
// states ST_IDLE, ST_BAL and ST_MED of the three-step sequencer. The input is
// ready again only once the median step has loaded its result, so the block
// does not take a new sample before the last one is through the sequencer.
// Reset zeroes both chain counts, which empties the store, and clears the
// output valid flag; no clearing pass runs.
// If the receiver stalls, the result stays in the output register while the
// next sample is still accepted and processed; that sample then waits in the
// median step until the register is taken.
`default_nettype none

module running_median #(
  parameter int unsigned CAPACITY = rm_pkg::CAPACITY_DEF
) (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  input  wire                                 in_valid_i,
  output logic                                in_ready_o,
  input  wire  signed [rm_pkg::SAMPLE_W-1:0]  sample_i,
  input  wire                                 restart_i,
  output logic                                out_valid_o,
  input  wire                                 out_ready_i,
  output logic signed [rm_pkg::SAMPLE_W-1:0]  median_value_o,
  output logic        [rm_pkg::COUNT_W-1:0]   sample_count_o,
  output logic                                overflow_o
);
  import rm_pkg::*;

  // The lower half sits in a descending chain, so its head is the largest
  // value of the lower half; the upper half sits in an ascending chain.
  // Either chain may briefly hold one extra sample before rebalancing.
  localparam int unsigned DEPTH = CAPACITY / 2 + 1;
  localparam int unsigned CW    = $clog2(DEPTH + 1);
  localparam int unsigned TW    = $clog2(CAPACITY + 1);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_BAL  = 3'b010,
    ST_MED  = 3'b100
  } state_e;

  state_e state_q, state_d;

  logic [CW-1:0] lo_cnt_q, lo_cnt_d;
  logic [CW-1:0] up_cnt_q, up_cnt_d;
  logic          rej_q, rej_d;

  logic                       out_valid_q, out_valid_d;
  logic signed [SAMPLE_W-1:0] med_q, med_d;
  logic [COUNT_W-1:0]         cnt_out_q, cnt_out_d;
  logic                       ovf_q, ovf_d;

  cell_ctrl_t                 lo_ctrl, up_ctrl;
  logic signed [SAMPLE_W-1:0] lo_head, up_head;

  logic          accept;
  logic [CW-1:0] eff_lo, eff_up;
  logic [CW-1:0] lo_cnt_ch, up_cnt_ch;
  logic [TW-1:0] eff_total, total;
  logic          full, to_lo, load_out;
  logic [SAMPLE_W:0] pair_sum, pair_half;

  rm_chain #(
    .DEPTH   (DEPTH),
    .DESCEND (1'b1),
    .CNT_W   (CW)
  ) u_lo_chain (
    .clk_i   (clk_i),
    .ctrl_i  (lo_ctrl),
    .count_i (lo_cnt_ch),
    .head_o  (lo_head)
  );

  rm_chain #(
    .DEPTH   (DEPTH),
    .DESCEND (1'b0),
    .CNT_W   (CW)
  ) u_up_chain (
    .clk_i   (clk_i),
    .ctrl_i  (up_ctrl),
    .count_i (up_cnt_ch),
    .head_o  (up_head)
  );

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  // A restart is seen by the insertion of the very same sample, so the
  // counts it works against are the cleared ones.
  assign eff_lo    = restart_i ? '0 : lo_cnt_q;
  assign eff_up    = restart_i ? '0 : up_cnt_q;
  assign eff_total = TW'(eff_lo) + TW'(eff_up);
  assign full      = (eff_total == TW'(CAPACITY));
  assign to_lo     = (eff_lo == '0) || ($signed(sample_i) <= $signed(lo_head));

  // The cells see the same counts as the insertion, so a restarting sample
  // lands in the first slot as if the store were already empty.
  assign lo_cnt_ch = accept ? eff_lo : lo_cnt_q;
  assign up_cnt_ch = accept ? eff_up : up_cnt_q;

  // Median from the two chain heads. With an even count the 33-bit sum is
  // halved and rounded toward zero: a negative odd sum gets one added back.
  assign total     = TW'(lo_cnt_q) + TW'(up_cnt_q);
  assign pair_sum  = {lo_head[SAMPLE_W-1], lo_head} + {up_head[SAMPLE_W-1], up_head};
  assign pair_half = {pair_sum[SAMPLE_W], pair_sum[SAMPLE_W:1]}
                   + {{SAMPLE_W{1'b0}}, pair_sum[SAMPLE_W] & pair_sum[0]};

  assign load_out = (state_q == ST_MED) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d     = state_q;
    lo_cnt_d    = lo_cnt_q;
    up_cnt_d    = up_cnt_q;
    rej_d       = rej_q;
    lo_ctrl     = '{op: OP_HOLD, data: sample_i};
    up_ctrl     = '{op: OP_HOLD, data: sample_i};
    out_valid_d = out_valid_q && !out_ready_i;
    med_d       = med_q;
    cnt_out_d   = cnt_out_q;
    ovf_d       = ovf_q;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          rej_d    = full;
          lo_cnt_d = eff_lo;
          up_cnt_d = eff_up;
          if (!full) begin
            if (to_lo) begin
              lo_ctrl.op = OP_INSERT;
              lo_cnt_d   = eff_lo + CW'(1);
            end else begin
              up_ctrl.op = OP_INSERT;
              up_cnt_d   = eff_up + CW'(1);
            end
          end
          state_d = ST_BAL;
        end
      end
      ST_BAL: begin
        // Keep the lower half equal to or one larger than the upper half.
        if (lo_cnt_q > up_cnt_q + CW'(1)) begin
          lo_ctrl.op   = OP_POP;
          up_ctrl      = '{op: OP_PUSH, data: lo_head};
          lo_cnt_d     = lo_cnt_q - CW'(1);
          up_cnt_d     = up_cnt_q + CW'(1);
        end else if (up_cnt_q > lo_cnt_q) begin
          up_ctrl.op   = OP_POP;
          lo_ctrl      = '{op: OP_PUSH, data: up_head};
          up_cnt_d     = up_cnt_q - CW'(1);
          lo_cnt_d     = lo_cnt_q + CW'(1);
        end
        state_d = ST_MED;
      end
      ST_MED: begin
        if (load_out) begin
          out_valid_d = 1'b1;
          med_d       = total[0] ? lo_head : pair_half[SAMPLE_W-1:0];
          cnt_out_d   = COUNT_W'(total);
          ovf_d       = rej_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      lo_cnt_q    <= '0;
      up_cnt_q    <= '0;
      rej_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      lo_cnt_q    <= lo_cnt_d;
      up_cnt_q    <= up_cnt_d;
      rej_q       <= rej_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    med_q     <= med_d;
    cnt_out_q <= cnt_out_d;
    ovf_q     <= ovf_d;
  end

  assign out_valid_o    = out_valid_q;
  assign median_value_o = med_q;
  assign sample_count_o = cnt_out_q;
  assign overflow_o     = ovf_q;

endmodule

`default_nettype wire

// ===== rtl/rm_cell.sv =====
`default_nettype none

// One slot of a sorted chain. Ascending chains keep the smallest value in
// slot 0, descending chains the largest.
module rm_cell #(
  parameter bit DESCEND = 1'b0
) (
  input  wire                                   clk_i,
  input  rm_pkg::cell_ctrl_t                    ctrl_i,
  input  wire                                   valid_i,
  input  wire                                   prev_valid_i,
  input  wire                                   prev_shift_i,
  input  wire  signed [rm_pkg::SAMPLE_W-1:0]    prev_value_i,
  input  wire  signed [rm_pkg::SAMPLE_W-1:0]    next_value_i,
  output logic signed [rm_pkg::SAMPLE_W-1:0]    value_o,
  output logic                                  shift_o
);
  import rm_pkg::*;

  logic signed [SAMPLE_W-1:0] value_q, value_d;
  logic                       after;

  // The held value belongs behind the broadcast value in chain order.
  assign after   = DESCEND ? ($signed(value_q) < $signed(ctrl_i.data))
                           : ($signed(value_q) > $signed(ctrl_i.data));
  assign shift_o = valid_i && after;
  assign value_o = value_q;

  always_comb begin
    value_d = value_q;
    unique case (ctrl_i.op)
      OP_HOLD: begin
        value_d = value_q;
      end
      OP_INSERT: begin
        if (prev_shift_i) begin
          value_d = prev_value_i;
        end else if (shift_o || (!valid_i && prev_valid_i)) begin
          value_d = ctrl_i.data;
        end
      end
      OP_POP: begin
        value_d = next_value_i;
      end
      OP_PUSH: begin
        value_d = prev_value_i;
      end
      default: begin
        value_d = value_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

endmodule

`default_nettype wire

// ===== rtl/rm_chain.sv =====
`default_nettype none

// A row of cells kept in sorted order. Slots below count_i hold data.
module rm_chain #(
  parameter int unsigned DEPTH   = 33,
  parameter bit          DESCEND = 1'b0,
  parameter int unsigned CNT_W   = $clog2(DEPTH + 1)
) (
  input  wire                                 clk_i,
  input  rm_pkg::cell_ctrl_t                  ctrl_i,
  input  wire  [CNT_W-1:0]                    count_i,
  output logic signed [rm_pkg::SAMPLE_W-1:0]  head_o
);
  import rm_pkg::*;

  logic signed [SAMPLE_W-1:0] val   [DEPTH];
  logic                       valid [DEPTH];
  logic                       shift [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [SAMPLE_W-1:0] prev_value;
    logic signed [SAMPLE_W-1:0] next_value;
    logic                       prev_valid;
    logic                       prev_shift;

    assign valid[i] = CNT_W'(i) < count_i;

    if (i == 0) begin : g_first
      assign prev_value = ctrl_i.data;
      assign prev_valid = 1'b1;
      assign prev_shift = 1'b0;
    end else begin : g_inner
      assign prev_value = val[i-1];
      assign prev_valid = valid[i-1];
      assign prev_shift = shift[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign next_value = val[i];
    end else begin : g_more
      assign next_value = val[i+1];
    end

    rm_cell #(
      .DESCEND (DESCEND)
    ) u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (ctrl_i),
      .valid_i      (valid[i]),
      .prev_valid_i (prev_valid),
      .prev_shift_i (prev_shift),
      .prev_value_i (prev_value),
      .next_value_i (next_value),
      .value_o      (val[i]),
      .shift_o      (shift[i])
    );
  end

  assign head_o = val[0];

endmodule

`default_nettype wire

// ===== rtl/rm_checker.sv =====
`default_nettype none

`include "running_median_assert.svh"

module rm_checker #(
  parameter int unsigned CAPACITY = rm_pkg::CAPACITY_DEF
) (
  input wire                                clk_i,
  input wire                                rst_ni,
  input wire                                in_valid_i,
  input wire                                in_ready_o,
  input wire                                out_valid_o,
  input wire                                out_ready_i,
  input wire signed [rm_pkg::SAMPLE_W-1:0]  median_value_o,
  input wire        [rm_pkg::COUNT_W-1:0]   sample_count_o,
  input wire                                overflow_o
);
  import rm_pkg::*;

  logic [COUNT_W-1:0]          cap_low;
  logic                        out_wait;
  logic [SAMPLE_W+COUNT_W:0]   out_payload;

  assign cap_low     = COUNT_W'(CAPACITY);
  assign out_wait    = out_valid_o && !out_ready_i;
  assign out_payload = {median_value_o, sample_count_o, overflow_o};

  // A waiting result keeps its payload until it is taken.
  `RM_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_wait, out_valid_o && $stable(out_payload))

  // After a transaction the input side is busy for the following cycle.
  `RM_ASSERT_NXT(a_in_busy, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o)

  // A reported result always counts at least one held sample.
  `RM_ASSERT_IMP(a_count_nonzero, clk_i, rst_ni, out_valid_o, sample_count_o != '0)

  // A rejected sample is only reported with the store full.
  `RM_ASSERT_IMP(a_ovf_full, clk_i, rst_ni, out_valid_o && overflow_o, sample_count_o == cap_low)

endmodule

bind running_median rm_checker #(.CAPACITY(CAPACITY)) u_rm_checker (.*);

`default_nettype wire
